/* rtl/core/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int MAX_BYTES = 3;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0]                           cnt;
    logic [KIND_W-1:0]                    kind;
    logic [MAX_BYTES-1:0][BYTE_W-1:0]     bytes;
  } job_t;

endpackage

/* rtl/core/jsu_front.sv */
`timescale 1ns / 1ps

module jsu_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [jsu_pkg::BYTE_W-1:0] in_byte,
  input  logic                       input_end,
  output logic                       push,
  output jsu_pkg::job_t              job
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U = 8'h75;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_new;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new = {cp_r[11:0], hex_val};

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    job         = '0;
    job.kind    = jsu_pkg::KIND_DATA;
    if (input_end) begin
      job.cnt  = 2'd1;
      job.kind = jsu_pkg::KIND_ERR;
      mode_nxt = MODE_IDLE;
      hex_cnt_nxt = 2'd0;
      cp_nxt = 16'd0;
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            mode_nxt = MODE_BODY;
            hex_cnt_nxt = 2'd0;
            cp_nxt = 16'd0;
          end else begin
            job.cnt  = 2'd1;
            job.kind = jsu_pkg::KIND_ERR;
          end
        end
        MODE_BODY: begin
          if (in_byte == CH_QUOTE) begin
            job.cnt  = 2'd1;
            job.kind = jsu_pkg::KIND_DONE;
            mode_nxt = MODE_IDLE;
            hex_cnt_nxt = 2'd0;
            cp_nxt = 16'd0;
          end else if (in_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            job.cnt      = 2'd1;
            job.bytes[0] = in_byte;
          end
        end
        MODE_ESC: begin
          job.cnt  = 2'd1;
          mode_nxt = MODE_BODY;
          unique case (in_byte)
            CH_QUOTE:  job.bytes[0] = CH_QUOTE;
            CH_BSLASH: job.bytes[0] = CH_BSLASH;
            CH_SLASH:  job.bytes[0] = CH_SLASH;
            8'h6E:     job.bytes[0] = 8'h0A;
            8'h74:     job.bytes[0] = 8'h09;
            8'h72:     job.bytes[0] = 8'h0D;
            8'h62:     job.bytes[0] = 8'h08;
            8'h66:     job.bytes[0] = 8'h0C;
            CH_U: begin
              job.cnt  = 2'd0;
              mode_nxt = MODE_HEX;
              hex_cnt_nxt = 2'd0;
              cp_nxt = 16'd0;
            end
            default: begin
              job.kind = jsu_pkg::KIND_ERR;
              mode_nxt = MODE_IDLE;
              hex_cnt_nxt = 2'd0;
              cp_nxt = 16'd0;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            job.cnt  = 2'd1;
            job.kind = jsu_pkg::KIND_ERR;
            mode_nxt = MODE_IDLE;
            hex_cnt_nxt = 2'd0;
            cp_nxt = 16'd0;
          end else if (hex_cnt_r == 2'd3) begin
            if (cp_new < 16'h0080) begin
              job.cnt      = 2'd1;
              job.bytes[0] = cp_new[7:0];
            end else if (cp_new < 16'h0800) begin
              job.cnt      = 2'd2;
              job.bytes[0] = 8'hC0 | {3'd0, cp_new[10:6]};
              job.bytes[1] = 8'h80 | {2'd0, cp_new[5:0]};
            end else begin
              job.cnt      = 2'd3;
              job.bytes[0] = 8'hE0 | {4'd0, cp_new[15:12]};
              job.bytes[1] = 8'h80 | {2'd0, cp_new[11:6]};
              job.bytes[2] = 8'h80 | {2'd0, cp_new[5:0]};
            end
            mode_nxt = MODE_BODY;
            hex_cnt_nxt = 2'd0;
            cp_nxt = 16'd0;
          end else begin
            cp_nxt = cp_new;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
      endcase
    end
  end

  assign push = accept && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

  a_hex_cnt_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_HEX) |-> (hex_cnt_r == 2'd0))
    else $error("hex digit count outside of hex escape");

  a_cp_cleared_outside_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_HEX) |-> (cp_r == 16'd0))
    else $error("code point held outside of hex escape");

endmodule

/* rtl/core/jsu_fifo.sv */
`timescale 1ns / 1ps

module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::job_t head,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  jsu_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count out of step with push");

endmodule

/* rtl/core/jsu_back.sv */
`timescale 1ns / 1ps

module jsu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jsu_pkg::job_t              head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [jsu_pkg::BYTE_W-1:0] out_tdata,
  output logic [jsu_pkg::KIND_W-1:0] out_tuser,
  output logic                       out_tlast
);

  logic [1:0] idx_r, idx_nxt;
  logic       xfer;

  assign out_tvalid = !empty;
  assign out_tuser  = head.kind;
  assign out_tlast  = (idx_r == head.cnt - 2'd1);
  assign xfer       = out_tvalid && out_tready;
  assign pop        = xfer && out_tlast;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_tdata = head.bytes[0];
      2'd1:    out_tdata = head.bytes[1];
      2'd2:    out_tdata = head.bytes[2];
      default: out_tdata = '0;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = out_tlast ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (idx_r < head.cnt))
    else $error("byte index beyond queued job");

endmodule

/* rtl/core/json_string_unescape.sv */
`timescale 1ns / 1ps

// Decodes one JSON string literal at a time, starting at its opening quote: plain bytes pass,
// backslash escapes and \uXXXX (as 1 to 3 UTF-8 bytes) are expanded, a closing quote gives a
// done marker and errors give an error marker. One input byte is taken per clock while the job
// queue has room; each produces 0 to 3 results, and the output side drains one result per clock
// while out_tready is high, from a queue of DEPTH decoded jobs; a \u escape making three bytes
// leaves as three results, and the input stalls only once the queue is full.
module json_string_unescape #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tuser,   // [0] input_end
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic [1:0]                 out_tuser,  // [1:0] kind
  output logic                       out_tlast
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  jsu_pkg::job_t job;
  jsu_pkg::job_t head;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .input_end (in_tuser),
    .push      (push),
    .job       (job)
  );

  jsu_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
